// ===== src/tnts_pkg.sv =====
`default_nettype none
package tnts_pkg;

  localparam int CoordW = 15;
  localparam int WideW  = 16;
  localparam int SqW    = 33;
  localparam int RootW  = 17;
  localparam int CostW  = 24;
  localparam logic [CostW-1:0] CostMax = '1;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_NEAREST = 2'd1,
    ACT_NEAR    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_FULL   = 2'd1,
    STS_PARENT = 2'd2,
    STS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_START_X   = 3'd0,
    CFG_START_Y   = 3'd1,
    CFG_GOAL_X    = 3'd2,
    CFG_GOAL_Y    = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R2_GO,
    ST_R2_WAIT,
    ST_READ,
    ST_D_GO,
    ST_D_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_G_GO,
    ST_G_WAIT,
    ST_T_GO,
    ST_T_WAIT,
    ST_EMIT,
    ST_NEAR_PUT,
    ST_NEXT,
    ST_FIN
  } state_t;

endpackage
`default_nettype wire

// ===== src/tnts_sqdist.sv =====
`default_nettype none
module tnts_sqdist (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [tnts_pkg::WideW-1:0] a_x,
  input  wire logic [tnts_pkg::WideW-1:0] a_y,
  input  wire logic [tnts_pkg::WideW-1:0] b_x,
  input  wire logic [tnts_pkg::WideW-1:0] b_y,
  output logic                           done,
  output logic [tnts_pkg::SqW-1:0]       sum
);
  import tnts_pkg::*;

  logic [WideW-1:0] dx_r, dy_r, op;
  logic [2*WideW-1:0] prod;
  logic [SqW-1:0] acc_r;
  logic busy_r, phase_r, done_r;

  assign op   = phase_r ? dy_r : dx_r;
  assign prod = op * op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= 1'b0;
      end else if (busy_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dx_r <= (a_x > b_x) ? a_x - b_x : b_x - a_x;
      dy_r <= (a_y > b_y) ? a_y - b_y : b_y - a_y;
    end else if (busy_r) begin
      if (phase_r) begin
        acc_r <= acc_r + SqW'(prod);
      end else begin
        acc_r <= SqW'(prod);
      end
    end
  end

  assign done = done_r;
  assign sum  = acc_r;

endmodule
`default_nettype wire

// ===== src/tnts_sqrt.sv =====
`default_nettype none
module tnts_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [tnts_pkg::SqW-1:0]   operand,
  output logic                            done,
  output logic [tnts_pkg::RootW-1:0]      root
);
  import tnts_pkg::*;

  localparam int VW = SqW + 2;

  logic [VW-1:0] v_r, r_r, bit_r, trial;
  logic busy_r, done_r;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= VW'(operand);
      r_r   <= '0;
      bit_r <= VW'(1) << (SqW - 1);
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r <= v_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[RootW-1:0];

endmodule
`default_nettype wire

// ===== src/tree_node_table_search.sv =====
`default_nettype none
// Insert: distance to the parent, square root, goal and threshold distances, then emit;
// a rejected insert skips to emit. Nearest: a distance per stored node, then one root.
// Radius query: squared radius, then per node a distance and, if inside the radius, a root.
// One item at a time; in_stall is high until the last result word is loaded, and a held
// result word stretches the cycle that loads the next one.
// Synchronous active-low reset idles the sequencer, sets count to 1, loads config defaults.
module tree_node_table_search #(
  parameter int MAX_NODES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [14:0] in_point_x,
  input  wire logic [14:0] in_point_y,
  input  wire logic [5:0]  in_parent_index,
  input  wire logic [15:0] in_radius,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [5:0]       out_node_index,
  output logic [15:0]      out_node_distance,
  output logic [23:0]      out_node_cost,
  output logic             out_goal_reached,
  output logic             out_last
);
  import tnts_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  state_t state_r, state_nxt;

  logic [CoordW-1:0] start_x_r, start_y_r, goal_x_r, goal_y_r;
  logic [WideW-1:0]  thr_r;

  logic [CoordW-1:0] mem_x [MAX_NODES];
  logic [CoordW-1:0] mem_y [MAX_NODES];
  logic [CostW-1:0]  mem_c [MAX_NODES];
  logic [CoordW-1:0] rd_x_r, rd_y_r;
  logic [CostW-1:0]  rd_c_r;
  logic              rd_root_r;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;

  logic [CW-1:0]     count_r;
  logic [IW-1:0]     idx_r;
  action_t           act_r;
  logic [CoordW-1:0] px_r, py_r;
  logic [5:0]        par_r;
  logic [WideW-1:0]  rad_r;

  logic [SqW-1:0]    r2_r, sq_r, gd_r;
  logic [CostW-1:0]  sel_cost_r, new_cost_r;
  logic [IW-1:0]     sel_idx_r;
  logic [RootW-1:0]  d_r;

  status_t           res_status_r;
  logic [5:0]        res_idx_r;
  logic [WideW-1:0]  res_dist_r;
  logic [CostW-1:0]  res_cost_r;
  logic              res_goal_r;

  logic              pend_valid_r;
  logic [IW-1:0]     pend_idx_r;
  logic [WideW-1:0]  pend_dist_r;
  logic [CostW-1:0]  pend_cost_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [5:0]        out_idx_r;
  logic [WideW-1:0]  out_dist_r;
  logic [CostW-1:0]  out_cost_r;
  logic              out_goal_r, out_last_r;

  logic sd_start, sd_done, sq_start, sq_done;
  logic [WideW-1:0] sa_x, sa_y, sb_x, sb_y;
  logic [SqW-1:0] sd_sum;
  logic [RootW-1:0] root;
  logic out_free, in_acc, take, last_idx, out_load;
  logic [CostW:0] cost_sum;

  assign out_free = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign last_idx = (CW'(idx_r) + CW'(1)) == count_r;
  assign rd_addr  = (act_r == ACT_INSERT) ? IW'(par_r) : idx_r;
  assign wr_en    = (state_r == ST_T_WAIT) && sd_done;
  assign cost_sum = {1'b0, sel_cost_r} + (CostW+1)'(root);
  assign out_load = out_free && ((state_r == ST_EMIT) || (state_r == ST_FIN) ||
                                 ((state_r == ST_NEAR_PUT) && pend_valid_r));

  always_comb begin
    unique case (act_r)
      ACT_INSERT:  take = 1'b1;
      ACT_NEAREST: take = (idx_r == '0) || (sd_sum < sq_r);
      ACT_NEAR:    take = sd_sum < r2_r;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    sa_x = {1'b0, px_r};
    sa_y = {1'b0, py_r};
    sb_x = rd_root_r ? {1'b0, start_x_r} : {1'b0, rd_x_r};
    sb_y = rd_root_r ? {1'b0, start_y_r} : {1'b0, rd_y_r};
    unique case (state_r)
      ST_R2_GO: begin
        sa_x = rad_r; sa_y = '0; sb_x = '0; sb_y = '0;
      end
      ST_T_GO: begin
        sa_x = thr_r; sa_y = '0; sb_x = '0; sb_y = '0;
      end
      ST_G_GO: begin
        sb_x = {1'b0, goal_x_r}; sb_y = {1'b0, goal_y_r};
      end
      default: ;
    endcase
  end

  assign sd_start = (state_r == ST_R2_GO) || (state_r == ST_D_GO) ||
                    (state_r == ST_G_GO) || (state_r == ST_T_GO);
  assign sq_start = (state_r == ST_SQ_GO);

  tnts_sqdist u_sqdist (
    .clk(clk), .rst_n(rst_n), .start(sd_start),
    .a_x(sa_x), .a_y(sa_y), .b_x(sb_x), .b_y(sb_y),
    .done(sd_done), .sum(sd_sum)
  );

  tnts_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .operand(sq_r),
    .done(sq_done), .root(root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_t'(in_action))
            ACT_INSERT: begin
              if (count_r >= CW'(MAX_NODES)) begin
                state_nxt = ST_EMIT;
              end else if (13'(in_parent_index) >= 13'(count_r)) begin
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = ST_READ;
              end
            end
            ACT_NEAREST: state_nxt = ST_READ;
            ACT_NEAR:    state_nxt = ST_R2_GO;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_R2_GO:   state_nxt = ST_R2_WAIT;
      ST_R2_WAIT: if (sd_done) state_nxt = ST_READ;
      ST_READ:    state_nxt = ST_D_GO;
      ST_D_GO:    state_nxt = ST_D_WAIT;
      ST_D_WAIT: begin
        if (sd_done) begin
          priority if (act_r == ACT_INSERT) begin
            state_nxt = ST_SQ_GO;
          end else if (act_r == ACT_NEAREST) begin
            state_nxt = last_idx ? ST_SQ_GO : ST_READ;
          end else begin
            state_nxt = take ? ST_SQ_GO : ST_NEXT;
          end
        end
      end
      ST_SQ_GO: state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (sq_done) begin
          priority if (act_r == ACT_INSERT) begin
            state_nxt = ST_G_GO;
          end else if (act_r == ACT_NEAREST) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_NEAR_PUT;
          end
        end
      end
      ST_G_GO:   state_nxt = ST_G_WAIT;
      ST_G_WAIT: if (sd_done) state_nxt = ST_T_GO;
      ST_T_GO:   state_nxt = ST_T_WAIT;
      ST_T_WAIT: if (sd_done) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      ST_NEAR_PUT: if (!pend_valid_r || out_free) state_nxt = ST_NEXT;
      ST_NEXT:   state_nxt = last_idx ? ST_FIN : ST_READ;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= CoordW'(1024);
      start_y_r <= CoordW'(1024);
      goal_x_r  <= CoordW'(8192);
      goal_y_r  <= CoordW'(8192);
      thr_r     <= WideW'(1024);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_X:   start_x_r <= cfg_wdata[CoordW-1:0];
        CFG_START_Y:   start_y_r <= cfg_wdata[CoordW-1:0];
        CFG_GOAL_X:    goal_x_r  <= cfg_wdata[CoordW-1:0];
        CFG_GOAL_Y:    goal_y_r  <= cfg_wdata[CoordW-1:0];
        CFG_THRESHOLD: thr_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[IW'(count_r)] <= px_r;
      mem_y[IW'(count_r)] <= py_r;
      mem_c[IW'(count_r)] <= new_cost_r;
    end
    rd_x_r    <= mem_x[rd_addr];
    rd_y_r    <= mem_y[rd_addr];
    rd_c_r    <= mem_c[rd_addr];
    rd_root_r <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= CW'(1);
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
      act_r        <= ACT_NONE;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        count_r <= count_r + CW'(1);
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            act_r        <= action_t'(in_action);
            idx_r        <= '0;
            pend_valid_r <= 1'b0;
          end
        end
        ST_NEAR_PUT: begin
          if (!pend_valid_r || out_free) begin
            pend_valid_r <= 1'b1;
          end
        end
        ST_D_WAIT: begin
          if (sd_done && act_r == ACT_NEAREST && !last_idx) begin
            idx_r <= idx_r + IW'(1);
          end
        end
        ST_NEXT: begin
          if (!last_idx) begin
            idx_r <= idx_r + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          px_r  <= in_point_x;
          py_r  <= in_point_y;
          par_r <= in_parent_index;
          rad_r <= in_radius;
          res_status_r <= (count_r >= CW'(MAX_NODES)) ? STS_FULL : STS_PARENT;
          res_idx_r  <= '0;
          res_dist_r <= '0;
          res_cost_r <= '0;
          res_goal_r <= 1'b0;
        end
      end
      ST_R2_WAIT: if (sd_done) r2_r <= sd_sum;
      ST_D_GO: sel_cost_r <= sel_cost_r;
      ST_D_WAIT: begin
        if (sd_done && take) begin
          sq_r       <= sd_sum;
          sel_idx_r  <= idx_r;
          sel_cost_r <= rd_root_r ? '0 : rd_c_r;
        end
      end
      ST_SQ_WAIT: begin
        if (sq_done) begin
          d_r          <= root;
          new_cost_r   <= cost_sum[CostW] ? CostMax : cost_sum[CostW-1:0];
          res_status_r <= STS_OK;
          res_idx_r    <= (act_r == ACT_INSERT) ? 6'(count_r) : 6'(sel_idx_r);
          res_dist_r   <= root[WideW-1:0];
          res_cost_r   <= (act_r == ACT_INSERT) ?
                          (cost_sum[CostW] ? CostMax : cost_sum[CostW-1:0]) : sel_cost_r;
        end
      end
      ST_G_WAIT: if (sd_done) gd_r <= sd_sum;
      ST_T_WAIT: if (sd_done) res_goal_r <= gd_r < sd_sum;
      ST_NEAR_PUT: begin
        if (!pend_valid_r || out_free) begin
          pend_idx_r  <= sel_idx_r;
          pend_dist_r <= d_r[WideW-1:0];
          pend_cost_r <= sel_cost_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      unique case (state_r)
        ST_EMIT: begin
          out_status_r <= res_status_r;
          out_idx_r    <= res_idx_r;
          out_dist_r   <= res_dist_r;
          out_cost_r   <= res_cost_r;
          out_goal_r   <= res_goal_r;
          out_last_r   <= 1'b1;
        end
        ST_NEAR_PUT, ST_FIN: begin
          out_status_r <= (state_r == ST_FIN && !pend_valid_r) ? STS_EMPTY : STS_OK;
          out_idx_r    <= pend_valid_r ? 6'(pend_idx_r) : '0;
          out_dist_r   <= pend_valid_r ? pend_dist_r : '0;
          out_cost_r   <= pend_valid_r ? pend_cost_r : '0;
          out_goal_r   <= 1'b0;
          out_last_r   <= (state_r == ST_FIN);
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_node_index    = out_idx_r;
  assign out_node_distance = out_dist_r;
  assign out_node_cost     = out_cost_r;
  assign out_goal_reached  = out_goal_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CW'(1)) && (count_r <= CW'(MAX_NODES)))
    else $error("node count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not advance node count");
  a_pend_near: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> act_r == ACT_NEAR)
    else $error("pending match outside radius query");
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> state_r == ST_IDLE)
    else $error("radius query did not finish");
`endif

endmodule
`default_nettype wire

// ===== tb/tnts_checker.sv =====
`default_nettype none
module tnts_checker #(
  parameter int MAX_NODES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [14:0] in_point_x,
  input  wire logic [14:0] in_point_y,
  input  wire logic [5:0]  in_parent_index,
  input  wire logic [15:0] in_radius,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [1:0]  out_status,
  input  wire logic [5:0]  out_node_index,
  input  wire logic [15:0] out_node_distance,
  input  wire logic [23:0] out_node_cost,
  input  wire logic        out_goal_reached,
  input  wire logic        out_last,
  output int               fail_count,
  output int               pending,
  output int               node_total
);
  import tnts_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [5:0]  index;
    logic [15:0] distance;
    logic [23:0] cost;
    logic        goal;
    logic        last;
  } hit_t;

  hit_t hit_q[$];

  logic [14:0] start_x, start_y, goal_x, goal_y;
  logic [15:0] goal_th;
  logic [14:0] tab_x[MAX_NODES];
  logic [14:0] tab_y[MAX_NODES];
  logic [23:0] tab_cost[MAX_NODES];
  int          count;

  assign pending    = hit_q.size();
  assign node_total = count;

  function automatic logic [16:0] isqrt(logic [32:0] v);
    logic [33:0] r, b, rem;
    rem = v;
    r   = '0;
    b   = 34'd1 << 32;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[16:0];
  endfunction

  function automatic logic [32:0] dist_sq(logic [14:0] ax, logic [14:0] ay,
                                          logic [14:0] bx, logic [14:0] by);
    logic [32:0] dx, dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return dx * dx + dy * dy;
  endfunction

  function automatic logic [14:0] pos_x(int i);
    return (i == 0) ? start_x : tab_x[i];
  endfunction

  function automatic logic [14:0] pos_y(int i);
    return (i == 0) ? start_y : tab_y[i];
  endfunction

  function automatic void enqueue_hit(hit_t h);
    hit_q.insert(hit_q.size(), h);
  endfunction

  task automatic predict_word(action_t act, logic [14:0] px, logic [14:0] py,
                              logic [5:0] par, logic [15:0] rad);
    hit_t        h;
    logic [32:0] s, best_sq, r2;
    logic [24:0] c;
    logic [16:0] d;
    int          best, found;
    h = '0;
    h.last = 1'b1;
    case (act)
      ACT_INSERT: begin
        if (count >= MAX_NODES) begin
          h.status = STS_FULL;
        end else if (par >= count) begin
          h.status = STS_PARENT;
        end else begin
          d = isqrt(dist_sq(px, py, pos_x(par), pos_y(par)));
          c = ((par == 0) ? 24'd0 : tab_cost[par]) + d;
          if (c > CostMax) c = CostMax;
          tab_x[count]    = px;
          tab_y[count]    = py;
          tab_cost[count] = c[23:0];
          h.status   = STS_OK;
          h.index    = 6'(count);
          h.distance = d[15:0];
          h.cost     = c[23:0];
          h.goal     = dist_sq(px, py, goal_x, goal_y) < goal_th * goal_th;
          count++;
        end
        enqueue_hit(h);
      end
      ACT_NEAREST: begin
        best    = 0;
        best_sq = dist_sq(px, py, start_x, start_y);
        for (int i = 1; i < count; i++) begin
          s = dist_sq(px, py, pos_x(i), pos_y(i));
          if (s < best_sq) begin
            best_sq = s;
            best    = i;
          end
        end
        h.status   = STS_OK;
        h.index    = 6'(best);
        h.distance = 16'(isqrt(best_sq));
        h.cost     = (best == 0) ? '0 : tab_cost[best];
        enqueue_hit(h);
      end
      ACT_NEAR: begin
        found = 0;
        r2    = rad * rad;
        for (int i = 0; i < count; i++) begin
          s = dist_sq(px, py, pos_x(i), pos_y(i));
          if (s < r2) begin
            h.status   = STS_OK;
            h.index    = 6'(i);
            h.distance = 16'(isqrt(s));
            h.cost     = (i == 0) ? '0 : tab_cost[i];
            h.last     = 1'b0;
            enqueue_hit(h);
            found++;
          end
        end
        if (found == 0) begin
          h = '0;
          h.status = STS_EMPTY;
          h.last   = 1'b1;
          enqueue_hit(h);
        end else begin
          hit_q[$].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    hit_t got, want;
    if (!rst_n) begin
      start_x    <= 15'd1024;
      start_y    <= 15'd1024;
      goal_x     <= 15'd8192;
      goal_y     <= 15'd8192;
      goal_th    <= 16'd1024;
      count      = 1;
      fail_count = 0;
      hit_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START_X:   start_x <= cfg_wdata[14:0];
          CFG_START_Y:   start_y <= cfg_wdata[14:0];
          CFG_GOAL_X:    goal_x  <= cfg_wdata[14:0];
          CFG_GOAL_Y:    goal_y  <= cfg_wdata[14:0];
          CFG_THRESHOLD: goal_th <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {status_t'(out_status), out_node_index, out_node_distance, out_node_cost,
               out_goal_reached, out_last};
        if (hit_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: %p", got);
        end else begin
          want = hit_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_word(action_t'(in_action), in_point_x, in_point_y, in_parent_index,
                     in_radius);
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  import tnts_pkg::*;

  localparam int WatchLimit = 400000;
  localparam int MAX_NODES_C = 64;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [14:0] in_point_x, in_point_y;
  logic [5:0]  in_parent_index;
  logic [15:0] in_radius;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [5:0]  out_node_index;
  logic [15:0] out_node_distance;
  logic [23:0] out_node_cost;
  logic        out_goal_reached;
  logic        out_last;
  int          fail_count, pending, node_total;
  int          idle_pct;
  int          hold_cycles;
  int          quiet;

  tree_node_table_search u_top (.*);

  tnts_checker u_chk (.*);

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WatchLimit) begin
      $display("tree_node_table_search regression: fail");
      $finish;
    end
  end

  task automatic send(action_t act, logic [14:0] px, logic [14:0] py, logic [5:0] par,
                      logic [15:0] rad);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_point_x      <= px;
    in_point_y      <= py;
    in_parent_index <= par;
    in_radius       <= rad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_word(int well);
    int       k;
    action_t  act;
    k = $urandom_range(99);
    act = (k < 35) ? ACT_INSERT : (k < 65) ? ACT_NEAREST : (k < 97) ? ACT_NEAR : ACT_NONE;
    if (well != 0)
      send(act, 15'($urandom_range(32767)), 15'($urandom_range(32767)),
           6'($urandom_range(node_total > 1 ? node_total - 1 : 0)),
           16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(6000)));
    else
      send(act, 15'($urandom), 15'($urandom), 6'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_action = '0; in_point_x = '0; in_point_y = '0;
    in_parent_index = '0; in_radius = '0; idle_pct = 12; hold_cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(ACT_NEAREST, 15'd0, 15'd0, 6'd0, 16'd0);
    send(ACT_NEAR, 15'd1024, 15'd1024, 6'd0, 16'd0);
    send(ACT_NEAR, 15'd1024, 15'd1024, 6'd0, 16'd1);
    send(ACT_INSERT, 15'd2048, 15'd1024, 6'd5, 16'd0);
    send(ACT_INSERT, 15'd8192, 15'd8192, 6'd0, 16'd0);
    send(ACT_INSERT, 15'd7000, 15'd8192, 6'd1, 16'd0);
    send(ACT_INSERT, 15'h7fff, 15'h7fff, 6'd2, 16'hffff);
    send(ACT_INSERT, 15'd0, 15'd0, 6'd3, 16'd0);
    send(ACT_NEAREST, 15'd8192, 15'd8192, 6'd0, 16'd0);
    send(ACT_NEAREST, 15'd4608, 15'd4608, 6'd0, 16'd0);
    send(ACT_NEAR, 15'd4000, 15'd4000, 6'd0, 16'hffff);
    send(ACT_NONE, 15'h7fff, 15'h7fff, 6'h3f, 16'hffff);
    send(ACT_INSERT, 15'd100, 15'd100, 6'h3f, 16'd0);
    drain();

    write_reg(CFG_START_X, 16'h7fff);
    write_reg(CFG_START_Y, 16'd0);
    write_reg(CFG_GOAL_X, 16'h7fff);
    write_reg(CFG_GOAL_Y, 16'h7fff);
    write_reg(CFG_THRESHOLD, 16'hffff);
    @(posedge clk);
    send(ACT_INSERT, 15'd0, 15'h7fff, 6'd0, 16'd0);
    send(ACT_NEAREST, 15'h7fff, 15'd0, 6'd0, 16'd0);
    for (int i = 0; i < 110; i++) random_word(i % 9 != 0);
    drain();

    write_reg(CFG_START_X, 16'd0);
    write_reg(CFG_START_Y, 16'h7fff);
    write_reg(CFG_GOAL_X, 16'd0);
    write_reg(CFG_GOAL_Y, 16'd0);
    write_reg(CFG_THRESHOLD, 16'd0);
    @(posedge clk);
    hold_cycles = 3000;
    for (int i = 0; i < 20; i++) random_word(1);
    drain();

    // fill the table, chaining each new node's cost on the previous node, then insert once more
    write_reg(CFG_THRESHOLD, 16'd30000);
    @(posedge clk);
    while (node_total < MAX_NODES_C) send(ACT_INSERT, (node_total % 2) ? 15'h7fff : 15'd0,
                                          (node_total % 2) ? 15'd0 : 15'h7fff,
                                          6'(node_total - 1), 16'd0);
    send(ACT_INSERT, 15'd5, 15'd5, 6'd0, 16'd0);
    send(ACT_NEAR, 15'd16384, 15'd16384, 6'd0, 16'hffff);
    drain();

    idle_pct = 0;
    for (int i = 0; i < 60; i++) random_word(1);
    idle_pct = 12;
    for (int i = 0; i < 150; i++) random_word(i % 10 != 0);
    drain();

    if (fail_count == 0)
      $display("tree_node_table_search regression: pass");
    else
      $display("tree_node_table_search regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
